// File: sv/bbf_pkg.sv
// ---------------------------------------------------------------------------
// bbf_pkg
// Shared types, constants and helpers of the fixed-divisor box blur.
// ---------------------------------------------------------------------------
`default_nettype none

package bbf_pkg;

    localparam int MAX_RADIUS = 3;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int RAD_W  = 2;
    localparam int WID_W  = 11;
    localparam int HGT_W  = 13;
    localparam int PIX_W  = 8;
    localparam int IDX_W  = 2;
    localparam int DAT_W  = 13;
    localparam int POS_W  = 23;
    localparam int LAG_W  = 13;
    localparam int ADDR_W = 13;
    localparam int SUM_W  = 14;
    localparam int RCP_W  = 21;
    localparam int RCP_SH = 20;
    localparam int CUR_W  = POS_W + 2;
    localparam int STP_W  = 3;

    localparam logic [IDX_W-1:0] CFG_RADIUS = 2'd0;
    localparam logic [IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [RAD_W-1:0] RADIUS_RST = 2'd1;
    localparam logic [WID_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [HGT_W-1:0] HEIGHT_RST = 13'd480;

    typedef struct packed {
        logic [RAD_W-1:0] radius;
        logic [WID_W-1:0] width;
        logic [HGT_W-1:0] height;
        logic [POS_W-1:0] total;
        logic [LAG_W-1:0] lag;
    } t_geom;

    typedef struct packed {
        logic              wr;
        logic [PIX_W-1:0]  pixel;
        logic [ADDR_W-1:0] waddr;
        logic              res;
        logic              last;
    } t_job;

    typedef struct packed {
        logic [POS_W-1:0] in_pos;
    } t_front_stat;

    typedef struct packed {
        logic [POS_W-1:0] out_pos;
    } t_back_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DRAIN,
        ST_DIV,
        ST_OUT
    } t_back_state;

    // ceil(2^20 / (2r+1)^2), exact floor quotient for any window sum
    function automatic logic [RCP_W-1:0] win_recip(input logic [RAD_W-1:0] r);
        logic [RCP_W-1:0] m;
        unique case (r)
            2'd0: m = 21'd1048576;
            2'd1: m = 21'd116509;
            2'd2: m = 21'd41944;
            2'd3: m = 21'd21400;
            default: m = 21'd1048576;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// File: sv/bbf_if.sv
// ---------------------------------------------------------------------------
// bbf_if
// Handshake channels of the box blur: pixel input, result output, config.
// ---------------------------------------------------------------------------
`default_nettype none

interface bbf_pix_if;
    import bbf_pkg::*;
    logic             valid;
    logic             ready;
    logic             command;
    logic [PIX_W-1:0] pixel_in;
    modport source(output valid, command, pixel_in, input ready);
    modport sink(input valid, command, pixel_in, output ready);
endinterface

interface bbf_res_if;
    import bbf_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             frame_last;
    modport source(output valid, pixel_out, frame_last, input ready);
    modport sink(input valid, pixel_out, frame_last, output ready);
endinterface

interface bbf_cfg_if;
    import bbf_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [DAT_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/bbf_front.sv
// ---------------------------------------------------------------------------
// bbf_front
// Accepts pixel words, tracks raster position and classifies each word
// into a store write and/or a result request.
// ---------------------------------------------------------------------------
`default_nettype none

module bbf_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    bbf_pix_if.sink                   i_pix,
    input  wire bbf_pkg::t_geom       i_geom,
    input  wire logic                 i_restart,
    output bbf_pkg::t_job             o_job,
    output logic                      o_job_valid,
    input  wire logic                 i_job_ready,
    output bbf_pkg::t_front_stat      o_stat
);
    import bbf_pkg::*;

    logic [POS_W-1:0] r_in_pos;
    logic [POS_W-1:0] n_in_pos;
    logic [POS_W:0]   last_pos;
    logic             accept;

    assign accept      = i_pix.valid && i_job_ready;
    assign i_pix.ready = i_job_ready;
    assign o_job_valid = i_pix.valid;
    assign last_pos    = {1'b0, i_geom.total} + {{(POS_W+1-LAG_W){1'b0}}, i_geom.lag}
                         - {{POS_W{1'b0}}, 1'b1};

    always_comb begin
        o_job.wr    = r_in_pos < i_geom.total;
        o_job.pixel = i_pix.command ? '0 : i_pix.pixel_in;
        o_job.waddr = r_in_pos[ADDR_W-1:0];
        o_job.res   = r_in_pos >= {{(POS_W-LAG_W){1'b0}}, i_geom.lag};
        o_job.last  = {1'b0, r_in_pos} == last_pos;
        n_in_pos    = o_job.last ? '0 : r_in_pos + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_in_pos <= '0;
        end else if (accept) begin
            r_in_pos <= n_in_pos;
        end
    end

    assign o_stat.in_pos = r_in_pos;

endmodule

`default_nettype wire

// File: sv/bbf_queue.sv
// ---------------------------------------------------------------------------
// bbf_queue
// Two-entry job queue between the front and back parts.
// ---------------------------------------------------------------------------
`default_nettype none

module bbf_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire bbf_pkg::t_job i_push_job,
    input  wire logic          i_push_valid,
    output logic               o_push_ready,
    output bbf_pkg::t_job      o_pop_job,
    output logic               o_pop_valid,
    input  wire logic          i_pop_ready
);
    import bbf_pkg::*;

    t_job       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_push_ready = r_cnt != 2'd2;
    assign o_pop_valid  = r_cnt != 2'd0;
    assign o_pop_job    = r_slot[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

`default_nettype wire

// File: sv/bbf_back.sv
// ---------------------------------------------------------------------------
// bbf_back
// Owns the pixel store; writes jobs, walks the window one read per cycle,
// divides the sum by a reciprocal multiply and presents the result.
// ---------------------------------------------------------------------------
`default_nettype none

module bbf_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire bbf_pkg::t_geom i_geom,
    input  wire logic           i_restart,
    input  wire bbf_pkg::t_job  i_job,
    input  wire logic           i_job_valid,
    output logic                o_job_ready,
    bbf_res_if.source           o_res,
    output bbf_pkg::t_back_stat o_stat
);
    import bbf_pkg::*;

    logic [PIX_W-1:0] r_mem [1 << ADDR_W];

    t_back_state r_state;
    t_back_state n_state;

    logic [POS_W-1:0]        r_out_pos;
    logic [WID_W-1:0]        r_out_col;
    logic [HGT_W-1:0]        r_out_row;
    logic signed [CUR_W-1:0] r_cur;
    logic signed [HGT_W:0]   r_y;
    logic signed [WID_W:0]   r_x;
    logic [STP_W-1:0]        r_dx;
    logic [STP_W-1:0]        r_dy;
    logic                    r_rd_vld;
    logic [PIX_W-1:0]        r_rd_data;
    logic [SUM_W-1:0]        r_sum;
    logic                    r_last;

    logic                     pop;
    logic                     in_frame;
    logic                     dx_end;
    logic                     dy_end;
    logic [STP_W-1:0]         span;
    logic signed [WID_W:0]    row_step;
    logic signed [WID_W:0]    x_start;
    logic [SUM_W+RCP_W-1:0]   quot_prod;
    logic                     out_fire;

    assign span      = {i_geom.radius, 1'b0};
    assign dx_end    = r_dx == span;
    assign dy_end    = r_dy == span;
    assign pop       = (r_state == ST_IDLE) && i_job_valid;
    assign out_fire  = o_res.valid && o_res.ready;
    assign quot_prod = {{RCP_W{1'b0}}, r_sum} * {{SUM_W{1'b0}}, win_recip(i_geom.radius)};
    assign row_step  = $signed({1'b0, i_geom.width})
                       - $signed({{(WID_W-RAD_W){1'b0}}, i_geom.radius, 1'b0});
    assign x_start   = $signed({1'b0, r_out_col})
                       - $signed({{(WID_W+1-RAD_W){1'b0}}, i_geom.radius});
    assign in_frame  = !r_x[WID_W] && (r_x[WID_W-1:0] < i_geom.width)
                       && !r_y[HGT_W] && (r_y[HGT_W-1:0] < i_geom.height);

    // next state and handshake outputs
    always_comb begin
        n_state     = r_state;
        o_job_ready = r_state == ST_IDLE;
        o_res.valid = r_state == ST_OUT;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid && i_job.res) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (dx_end && dy_end) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_DIV;
            ST_DIV:   n_state = ST_OUT;
            ST_OUT: begin
                if (o_res.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // pixel store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (pop && i_job.wr) begin
            r_mem[i_job.waddr] <= i_job.pixel;
        end
        r_rd_data <= r_mem[r_cur[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == ST_SUM) && in_frame;
        end
    end

    // window walk, accumulate and divide
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (pop && i_job.res) begin
                    r_cur  <= $signed({2'b0, r_out_pos})
                              - $signed({{(CUR_W-LAG_W){1'b0}}, i_geom.lag});
                    r_y    <= $signed({1'b0, r_out_row})
                              - $signed({{(HGT_W+1-RAD_W){1'b0}}, i_geom.radius});
                    r_x    <= x_start;
                    r_dx   <= '0;
                    r_dy   <= '0;
                    r_sum  <= '0;
                    r_last <= i_job.last;
                end
            end
            ST_SUM: begin
                if (r_rd_vld) begin
                    r_sum <= r_sum + {{(SUM_W-PIX_W){1'b0}}, r_rd_data};
                end
                if (!dx_end) begin
                    r_dx  <= r_dx + 1'b1;
                    r_x   <= r_x + 1'b1;
                    r_cur <= r_cur + 1'b1;
                end else begin
                    r_dx  <= '0;
                    r_x   <= x_start;
                    r_dy  <= r_dy + 1'b1;
                    r_y   <= r_y + 1'b1;
                    r_cur <= r_cur + CUR_W'(row_step);
                end
            end
            ST_DRAIN: begin
                if (r_rd_vld) begin
                    r_sum <= r_sum + {{(SUM_W-PIX_W){1'b0}}, r_rd_data};
                end
            end
            ST_DIV: begin
                // quotient is the top bits of sum times the reciprocal
                r_sum <= {{(SUM_W-PIX_W){1'b0}}, quot_prod[RCP_SH +: PIX_W]};
            end
            ST_OUT: ;
            default: ;
        endcase
    end

    // position of the next result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_out_pos <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (out_fire) begin
            if (r_last) begin
                r_out_pos <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                r_out_pos <= r_out_pos + 1'b1;
                if (r_out_col + 1'b1 >= i_geom.width) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + 1'b1;
                end else begin
                    r_out_col <= r_out_col + 1'b1;
                end
            end
        end
    end

    assign o_res.pixel_out  = r_sum[PIX_W-1:0];
    assign o_res.frame_last = r_last;
    assign o_stat.out_pos   = r_out_pos;

endmodule

`default_nettype wire

// File: sv/box_blur_fixed_divisor.sv
// latency: a result leaves radius*width+radius words after its pixel; once its
//   releasing word is taken, it passes the queue and the sum, drain and divide states before it shows
// pacing: a word with no result leaves the back part idle for the next word, one with
//   a result holds it through the window walk, set by the single store read port
// reset: synchronous, clears positions and queue; registers return to radius 1,
//   width 640, height 480; store contents are not cleared
// ---------------------------------------------------------------------------
// box_blur_fixed_divisor
// Streaming box blur of a grey frame with a constant (2r+1)^2 divisor.
// ---------------------------------------------------------------------------
`default_nettype none

module box_blur_fixed_divisor (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bbf_pix_if.sink   i_pix,
    bbf_res_if.source o_res,
    bbf_cfg_if.sink   i_cfg
);
    import bbf_pkg::*;

    logic [RAD_W-1:0] r_radius;
    logic [WID_W-1:0] r_width;
    logic [HGT_W-1:0] r_height;

    t_geom       geom;
    logic        cfg_wr;
    logic        cfg_restart;
    t_job        f_job;
    logic        f_valid;
    logic        f_ready;
    t_job        q_job;
    logic        q_valid;
    logic        q_ready;
    t_front_stat f_stat;
    t_back_stat  b_stat;
    logic [POS_W:0] max_pos;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;
    // writes to an unused index leave the frame running
    assign cfg_restart = cfg_wr && (i_cfg.index == CFG_RADIUS || i_cfg.index == CFG_WIDTH
                                    || i_cfg.index == CFG_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (cfg_wr) begin
            unique case (i_cfg.index)
                CFG_RADIUS: r_radius <= i_cfg.data[RAD_W-1:0];
                CFG_WIDTH:  r_width  <= i_cfg.data[WID_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // clamp registers into the supported frame
    always_comb begin
        geom.radius = r_radius;
        if (r_width == '0) begin
            geom.width = WID_W'(1);
        end else if (r_width > WID_W'(MAX_WIDTH)) begin
            geom.width = WID_W'(MAX_WIDTH);
        end else begin
            geom.width = r_width;
        end
        if (r_height == '0) begin
            geom.height = HGT_W'(1);
        end else if (r_height > HGT_W'(MAX_HEIGHT)) begin
            geom.height = HGT_W'(MAX_HEIGHT);
        end else begin
            geom.height = r_height;
        end
        geom.total = {{(POS_W-WID_W){1'b0}}, geom.width}
                     * {{(POS_W-HGT_W){1'b0}}, geom.height};
        geom.lag   = {{(LAG_W-RAD_W){1'b0}}, geom.radius}
                     * {{(LAG_W-WID_W){1'b0}}, geom.width}
                     + {{(LAG_W-RAD_W){1'b0}}, geom.radius};
    end

    bbf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .i_geom      (geom),
        .i_restart   (cfg_restart),
        .o_job       (f_job),
        .o_job_valid (f_valid),
        .i_job_ready (f_ready),
        .o_stat      (f_stat)
    );

    bbf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_job   (f_job),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .o_pop_job    (q_job),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready)
    );

    bbf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_geom      (geom),
        .i_restart   (cfg_restart),
        .i_job       (q_job),
        .i_job_valid (q_valid),
        .o_job_ready (q_ready),
        .o_res       (o_res),
        .o_stat      (b_stat)
    );

    assign max_pos = {1'b0, geom.total} + {{(POS_W+1-LAG_W){1'b0}}, geom.lag};

    a_frame_end_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.ready && o_res.frame_last |=> b_stat.out_pos == '0)
        else $error("output position not rewound after frame end");

    a_in_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, f_stat.in_pos} < max_pos)
        else $error("input position ran past the frame plus lag");

    a_out_behind_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> b_stat.out_pos <= f_stat.in_pos || f_stat.in_pos == '0
                        || q_valid)
        else $error("result position ahead of input position");

endmodule

`default_nettype wire

// File: tb/box_blur_fixed_divisor_tb.sv
// ---------------------------------------------------------------------------
// box_blur_fixed_divisor_tb
// Self-checking bench for the fixed-divisor box blur. A scoreboard class keeps
// its own copy of the pixel store, position counters and registers, predicts
// every mean from the accepted words and checks each result word in order.
// Directed register extremes come first, then random small frames under
// varying idle patterns, a long result hold-off and drain pauses.
// ---------------------------------------------------------------------------
`default_nettype none

module box_blur_fixed_divisor_tb;
    import bbf_pkg::*;

    localparam bit CMD_PIXEL = 1'b0;
    localparam bit CMD_FLUSH = 1'b1;
    localparam int STORE_DEPTH = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 150;

    typedef struct {
        logic [PIX_W-1:0] mean;
        logic             last;
    } t_blur_result;

    class blur_scoreboard;
        logic [PIX_W-1:0] store[STORE_DEPTH];
        int unsigned in_row, in_col, out_row, out_col;
        logic [RAD_W-1:0] radius;
        logic [WID_W-1:0] width;
        logic [HGT_W-1:0] height;
        t_blur_result expected_means[$];
        int errors;

        function void restart();
            in_row = 0;
            in_col = 0;
            out_row = 0;
            out_col = 0;
        endfunction

        function void clear();
            radius = RADIUS_RST;
            width  = WIDTH_RST;
            height = HEIGHT_RST;
            errors = 0;
            restart();
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [DAT_W-1:0] data);
            case (idx)
                CFG_RADIUS: radius = data[RAD_W-1:0];
                CFG_WIDTH:  width  = data[WID_W-1:0];
                CFG_HEIGHT: height = data[HGT_W-1:0];
                default: return;
            endcase
            restart();
        endfunction

        function void note_word(bit cmd, logic [PIX_W-1:0] pix);
            int unsigned r, w, h, total, lag, t, side, sum;
            int y, x;
            t_blur_result res;
            r = (radius > MAX_RADIUS) ? MAX_RADIUS : radius;
            w = (width == 0) ? 1 : ((width > MAX_WIDTH) ? MAX_WIDTH : width);
            h = (height == 0) ? 1 : ((height > MAX_HEIGHT) ? MAX_HEIGHT : height);
            total = w * h;
            lag = r * w + r;
            t = in_row * w + in_col;
            if (t < total)
                store[t % STORE_DEPTH] = (cmd == CMD_PIXEL) ? pix : '0;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
            if (t < lag)
                return;
            sum = 0;
            for (int dy = -int'(r); dy <= int'(r); dy++) begin
                y = int'(out_row) + dy;
                if (y < 0 || y >= int'(h)) continue;
                for (int dx = -int'(r); dx <= int'(r); dx++) begin
                    x = int'(out_col) + dx;
                    if (x < 0 || x >= int'(w)) continue;
                    sum += store[(y * w + x) % STORE_DEPTH];
                end
            end
            side = 2 * r + 1;
            res.mean = PIX_W'(sum / (side * side));
            res.last = ((out_row * w + out_col) == total - 1);
            expected_means.push_back(res);
            if (res.last) begin
                restart();
            end else begin
                out_col++;
                if (out_col >= w) begin
                    out_col = 0;
                    out_row++;
                end
            end
        endfunction

        function void check_result(logic [PIX_W-1:0] mean, logic last);
            t_blur_result exp_res;
            if (expected_means.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: mean %0d last %0d", mean, last);
                return;
            end
            exp_res = expected_means.pop_front();
            if (mean !== exp_res.mean || last !== exp_res.last) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected mean %0d last %0d, got mean %0d last %0d",
                             exp_res.mean, exp_res.last, mean, last);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bbf_pix_if pix_ch();
    bbf_res_if res_ch();
    bbf_cfg_if cfg_ch();

    box_blur_fixed_divisor u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch.sink),
        .o_res   (res_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    blur_scoreboard sb = new();

    int src_idle_pct = 0;
    int rcv_idle_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int random_words = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // result side: random stalls, long hold-off on request, checking
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready)
                sb.check_result(res_ch.pixel_out, res_ch.frame_last);
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_word(bit cmd, logic [PIX_W-1:0] pix);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            pix_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_ch.valid    <= 1'b1;
        pix_ch.command  <= cmd;
        pix_ch.pixel_in <= pix;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
        sb.note_word(cmd, pix);
    endtask

    task automatic drain();
        pix_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_means.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [DAT_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        sb.write_reg(idx, data);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_geometry(int r, int w, int h);
        drain();
        write_reg(CFG_RADIUS, DAT_W'(r));
        write_reg(CFG_WIDTH, DAT_W'(w));
        write_reg(CFG_HEIGHT, DAT_W'(h));
        @(posedge i_clk);
    endtask

    // well-formed frame plus flush tail, with occasional stray words
    task automatic send_frame(int r, int w, int h);
        for (int i = 0; i < w * h; i++) begin
            send_word($urandom_range(0, 9) == 0, PIX_W'($urandom()));
            random_words++;
        end
        for (int i = 0; i < r * w + r; i++) begin
            send_word($urandom_range(0, 3) != 0, PIX_W'($urandom()));
            random_words++;
        end
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 5)) begin
                send_word($urandom_range(0, 1), PIX_W'($urandom()));
                random_words++;
            end
        end
    endtask

    initial begin
        int r, w, h;
        bit hold_now;
        hold_now        = 1'b0;
        i_rst_n         = 1'b0;
        pix_ch.valid    = 1'b0;
        pix_ch.command  = CMD_PIXEL;
        pix_ch.pixel_in = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_RADIUS;
        cfg_ch.data     = '0;
        sb.clear();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry: long lag, no results yet
        send_word(CMD_PIXEL, 8'd0);
        send_word(CMD_PIXEL, 8'd255);
        send_word(CMD_FLUSH, 8'd255);
        send_word(CMD_PIXEL, 8'h55);
        send_word(CMD_PIXEL, 8'hAA);

        // single pixel frames, flush inside the frame acts as a zero pixel
        set_geometry(0, 1, 1);
        send_word(CMD_PIXEL, 8'd255);
        send_word(CMD_FLUSH, 8'd200);
        send_word(CMD_PIXEL, 8'hAA);

        // zero width and height act as one, radius 3 darkens to sum/49
        set_geometry(3, 0, 0);
        send_word(CMD_PIXEL, 8'd200);
        send_word(CMD_PIXEL, 8'd17);
        send_word(CMD_FLUSH, 8'd0);
        send_word(CMD_PIXEL, 8'd255);
        send_word(CMD_FLUSH, 8'd0);

        // oversized width and height clamp to the maximum
        set_geometry(1, 2047, 8191);
        repeat (4) send_word(CMD_PIXEL, 8'd255);
        set_geometry(0, 2047, 8191);
        repeat (5) send_word(CMD_PIXEL, PIX_W'($urandom()));

        // pixels after the frame count as flush ticks
        set_geometry(1, 2, 1);
        send_word(CMD_PIXEL, 8'd255);
        send_word(CMD_PIXEL, 8'd255);
        send_word(CMD_PIXEL, 8'd9);
        send_word(CMD_PIXEL, 8'd9);

        while (random_words < 700) begin
            if (random_words < 230) begin
                src_idle_pct = 28;
                rcv_idle_pct = 87;
            end else if (random_words < 460) begin
                src_idle_pct = 87;
                rcv_idle_pct = 28;
            end else begin
                if (src_idle_pct != 0)
                    hold_now = 1'b1;
                src_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            r = $urandom_range(0, 3);
            w = ($urandom_range(0, 7) == 0 && random_words < 500) ?
                $urandom_range(13, 40) : $urandom_range(1, 12);
            h = $urandom_range(1, 6);
            set_geometry(r, w, h);
            // receiver holds off while the frame is offered, so the block fills
            if (hold_now) begin
                hold_requests++;
                hold_now = 1'b0;
            end
            repeat ($urandom_range(1, 3)) begin
                if (random_words < 700)
                    send_frame(r, w, h);
            end
        end

        drain();
        if (sb.errors == 0 && sb.expected_means.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
